>>> rtl/core/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg: shared types and constants for the depth-fill rasterizer
// Request codes, field widths and default store dimensions.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

  localparam int COORD_W  = 14;   // vertex coordinate, two's complement
  localparam int DEPTH_W  = 16;   // depth value, unsigned fixed point
  localparam int RPOS_W   = 9;    // read position
  localparam int COUNT_W  = 19;   // updated-pixel count
  localparam int DIM_W    = 10;   // screen dimension register
  localparam int CIDX_W   = 1;    // config register index
  localparam int DIFF_W   = 15;   // coordinate difference
  localparam int EDGE_W   = 32;   // edge function value
  localparam int NUM_W    = 49;   // weighted depth sum
  localparam int AREA_W   = 31;   // positive doubled area

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH = '1;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_TRI   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [DEPTH_W-1:0] depth_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;

  // top-left rule for edge p->q
  function automatic logic top_left(coord_t px, coord_t py, coord_t qx, coord_t qy);
    return ((py == qy) && (px < qx)) || (py < qy);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tdf_if.sv
// ----------------------------------------------------------------------------
// tdf_if: request, result and configuration channels
// Valid/ready streams; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdf_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  tdf_pkg::coord_t            ax, ay, bx, by, cx, cy;
  tdf_pkg::depth_t            az, bz, cz;
  logic [tdf_pkg::RPOS_W-1:0] read_x, read_y;

  modport source (output valid, req_type, ax, ay, az, bx, by, bz, cx, cy, cz,
                  read_x, read_y, input ready);
  modport sink   (input valid, req_type, ax, ay, az, bx, by, bz, cx, cy, cz,
                  read_x, read_y, output ready);
endinterface

interface tdf_res_if;
  logic                        valid;
  logic                        ready;
  tdf_pkg::depth_t             depth_out;
  logic [tdf_pkg::COUNT_W-1:0] pixels_updated;

  modport source (output valid, depth_out, pixels_updated, input ready);
  modport sink   (input valid, depth_out, pixels_updated, output ready);
endinterface

interface tdf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tdf_pkg::CIDX_W-1:0] index;
  logic [tdf_pkg::DIM_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tdf_ram.sv
// ----------------------------------------------------------------------------
// tdf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tdf_div.sv
// ----------------------------------------------------------------------------
// tdf_div: serial restoring divider for the interpolated depth
// One quotient bit per cycle; quotient is known to fit the depth width.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tdf_pkg::NUM_W-1:0]     num,
  input  wire logic [tdf_pkg::AREA_W-1:0]    den,
  output logic                               busy,
  output logic                               done,
  output tdf_pkg::depth_t                    quot
);
  import tdf_pkg::*;

  localparam int STEP_W = $clog2(DEPTH_W);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [STEP_W-1:0] step;
  logic              fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= num;
        dsh  <= NUM_W'(den) << (DEPTH_W - 1);
        step <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        quot <= {quot[DEPTH_W-2:0], fits};
        dsh  <= dsh >> 1;
        step <= step + 1'b1;
        if (step == STEP_W'(DEPTH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/triangle_depth_fill_top.sv
// Sequence: a read runs S_RD, S_RDW, S_DONE; a clear writes all of the
//   MAX_WIDTH*MAX_HEIGHT entries; a triangle runs box, setup and check, then
//   walks the clamped box: covered pixels get multiply, divide, compare/write.
// Throughput: one request at a time; the walker, the shared multiplier and the
//   serial divider set the rate. A new request is taken while a result waits.
// Reset: control state clears; the depth store is undefined until a clear.
// ----------------------------------------------------------------------------
// triangle_depth_fill_top: depth-only triangle rasterizer with depth store
// Clear, triangle draw with depth test, and single-entry read requests.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_depth_fill_top #(
  parameter int MAX_WIDTH  = tdf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tdf_pkg::DEF_MAX_HEIGHT
) (
  input wire logic clk,
  input wire logic rst,
  tdf_req_if.sink   req,
  tdf_res_if.source res,
  tdf_cfg_if.sink   cfg
);
  import tdf_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int WIDE_W = 13;

  typedef enum logic [3:0] {
    S_IDLE, S_BOX, S_SETUP, S_CHECK, S_PIX, S_MUL, S_DIVS, S_DIV, S_CMP,
    S_CLR, S_RD, S_RDW, S_DONE
  } state_t;

  state_t state;

  // ---- configuration: saturate to 1..MAX ----
  logic [DIM_W-1:0] width_in_use, height_in_use;

  function automatic logic [DIM_W-1:0] sat_dim(logic [DIM_W-1:0] v, int maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (WIDE_W'(v) > WIDE_W'(maxv)) r = DIM_W'(maxv);
    return r;
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= sat_dim(DIM_W'(512), MAX_WIDTH);
      height_in_use <= sat_dim(DIM_W'(512), MAX_HEIGHT);
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_WIDTH:  width_in_use  <= sat_dim(cfg.data, MAX_WIDTH);
        CFG_HEIGHT: height_in_use <= sat_dim(cfg.data, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  // ---- latched request ----
  coord_t            ax, ay, bx, by, cx, cy;
  depth_t            az, bz, cz;
  logic [RPOS_W-1:0] rx, ry;

  // ---- bounding box, clamped to the screen ----
  diff_t minx_c, maxx_c, miny_c, maxy_c;
  always_comb begin
    minx_c = diff_t'(ax);
    if (diff_t'(bx) < minx_c) minx_c = diff_t'(bx);
    if (diff_t'(cx) < minx_c) minx_c = diff_t'(cx);
    maxx_c = diff_t'(ax);
    if (diff_t'(bx) > maxx_c) maxx_c = diff_t'(bx);
    if (diff_t'(cx) > maxx_c) maxx_c = diff_t'(cx);
    miny_c = diff_t'(ay);
    if (diff_t'(by) < miny_c) miny_c = diff_t'(by);
    if (diff_t'(cy) < miny_c) miny_c = diff_t'(cy);
    maxy_c = diff_t'(ay);
    if (diff_t'(by) > maxy_c) maxy_c = diff_t'(by);
    if (diff_t'(cy) > maxy_c) maxy_c = diff_t'(cy);
    if (minx_c < 0) minx_c = '0;
    if (miny_c < 0) miny_c = '0;
    if (maxx_c > diff_t'({1'b0, width_in_use}) - diff_t'(1))
      maxx_c = diff_t'({1'b0, width_in_use}) - diff_t'(1);
    if (maxy_c > diff_t'({1'b0, height_in_use}) - diff_t'(1))
      maxy_c = diff_t'({1'b0, height_in_use}) - diff_t'(1);
  end

  logic [DIM_W-1:0] minx, maxx, miny, maxy;
  logic             box_empty;

  // ---- edge steps and top-left flags ----
  // edge 0: b->c, edge 1: c->a, edge 2: a->b
  edge_t step_x [3];
  edge_t step_y [3];
  logic  tl [3];
  always_comb begin
    step_x[0] = EDGE_W'(diff_t'(by) - diff_t'(cy));
    step_y[0] = EDGE_W'(diff_t'(cx) - diff_t'(bx));
    step_x[1] = EDGE_W'(diff_t'(cy) - diff_t'(ay));
    step_y[1] = EDGE_W'(diff_t'(ax) - diff_t'(cx));
    step_x[2] = EDGE_W'(diff_t'(ay) - diff_t'(by));
    step_y[2] = EDGE_W'(diff_t'(bx) - diff_t'(ax));
    tl[0] = top_left(bx, by, cx, cy);
    tl[1] = top_left(cx, cy, ax, ay);
    tl[2] = top_left(ax, ay, bx, by);
  end

  // ---- shared multiplier ----
  // setup: acc[0] = area, acc[1..3] = edge values at the box corner
  logic [3:0]               sstep;
  logic [1:0]               acc_sel;
  logic [1:0]               mstep;
  edge_t                    acc [4];
  logic signed [32:0]       mul_a;
  logic signed [16:0]       mul_b;
  logic signed [49:0]       prod;
  coord_t                   ppx, ppy, pqx, pqy;
  diff_t                    ptx, pty;
  edge_t                    w  [3];
  edge_t                    wr [3];

  // accumulator fed by the product of the previous setup step
  assign acc_sel = 2'((sstep - 4'd1) >> 1);

  always_comb begin
    ppx = ax; ppy = ay; pqx = bx; pqy = by;
    ptx = diff_t'(cx); pty = diff_t'(cy);
    case (sstep[2:1])
      2'd1: begin
        ppx = bx; ppy = by; pqx = cx; pqy = cy;
        ptx = diff_t'({1'b0, minx}); pty = diff_t'({1'b0, miny});
      end
      2'd2: begin
        ppx = cx; ppy = cy; pqx = ax; pqy = ay;
        ptx = diff_t'({1'b0, minx}); pty = diff_t'({1'b0, miny});
      end
      2'd3: begin
        ppx = ax; ppy = ay; pqx = bx; pqy = by;
        ptx = diff_t'({1'b0, minx}); pty = diff_t'({1'b0, miny});
      end
      default: ;
    endcase
    if (state == S_MUL) begin
      case (mstep)
        2'd0:    begin mul_a = 33'(w[0]); mul_b = 17'({1'b0, az}); end
        2'd1:    begin mul_a = 33'(w[1]); mul_b = 17'({1'b0, bz}); end
        default: begin mul_a = 33'(w[2]); mul_b = 17'({1'b0, cz}); end
      endcase
    end else if (!sstep[0]) begin
      mul_a = 33'(ptx - diff_t'(pqx));
      mul_b = 17'(diff_t'(ppy) - diff_t'(pqy));
    end else begin
      mul_a = 33'(pty - diff_t'(pqy));
      mul_b = 17'(diff_t'(ppx) - diff_t'(pqx));
    end
  end

  // ---- pixel walker ----
  logic [DIM_W-1:0] px, py;
  logic             covered, last_x, last_y;
  logic [AW-1:0]    pix_addr;

  always_comb begin
    covered = 1'b1;
    for (int e = 0; e < 3; e++) begin
      if (!((w[e] > 0) || ((w[e] == 0) && tl[e]))) covered = 1'b0;
    end
  end
  assign last_x   = (px == maxx);
  assign last_y   = (py == maxy);
  assign pix_addr = AW'(py) * AW'(MAX_WIDTH) + AW'(px);

  // ---- depth store and divider ----
  logic [NUM_W-1:0]   num;
  logic               div_busy, div_done;
  depth_t             quot, rd_data;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr, clr_addr;
  depth_t             wr_data;
  logic               rd_in_store;

  assign rd_in_store = (WIDE_W'(rx) < WIDE_W'(MAX_WIDTH)) &&
                       (WIDE_W'(ry) < WIDE_W'(MAX_HEIGHT));
  assign rd_en   = (state == S_PIX && covered) || (state == S_RD);
  assign rd_addr = (state == S_RD) ? AW'(ry) * AW'(MAX_WIDTH) + AW'(rx) : pix_addr;
  assign wr_en   = (state == S_CLR) || (state == S_CMP && quot < rd_data);
  assign wr_addr = (state == S_CLR) ? clr_addr : pix_addr;
  assign wr_data = (state == S_CLR) ? FAR_DEPTH : quot;

  tdf_ram #(.WIDTH(DEPTH_W), .DEPTH(DEPTH)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  tdf_div u_div (
    .clk(clk), .rst(rst), .start(state == S_DIVS), .num(num),
    .den(acc[0][AREA_W-1:0]), .busy(div_busy), .done(div_done), .quot(quot)
  );

  // ---- control ----
  depth_t             depth_w;
  logic [COUNT_W-1:0] cnt;

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      // S_DONE handles its own result register
      if (res.valid && res.ready && state != S_DONE) res.valid <= 1'b0;
      case (state)
        S_IDLE: if (req.valid) begin
          ax <= req.ax; ay <= req.ay; az <= req.az;
          bx <= req.bx; by <= req.by; bz <= req.bz;
          cx <= req.cx; cy <= req.cy; cz <= req.cz;
          rx <= req.read_x; ry <= req.read_y;
          depth_w  <= '0;
          cnt      <= '0;
          clr_addr <= '0;
          sstep    <= '0;
          case (req_t'(req.req_type))
            REQ_CLEAR: state <= S_CLR;
            REQ_TRI:   state <= S_BOX;
            REQ_READ:  state <= S_RD;
            default:   state <= S_DONE;
          endcase
        end
        S_BOX: begin
          minx      <= DIM_W'(minx_c);
          maxx      <= DIM_W'(maxx_c);
          miny      <= DIM_W'(miny_c);
          maxy      <= DIM_W'(maxy_c);
          box_empty <= (minx_c > maxx_c) || (miny_c > maxy_c);
          state     <= S_SETUP;
        end
        S_SETUP: begin
          prod <= mul_a * mul_b;
          if (sstep != '0) begin
            if (sstep[0]) acc[acc_sel] <= edge_t'(prod);
            else          acc[acc_sel] <= acc[acc_sel] - edge_t'(prod);
          end
          sstep <= sstep + 1'b1;
          if (sstep == 4'd8) state <= S_CHECK;
        end
        S_CHECK: begin
          if (box_empty || acc[0] <= 0) begin
            state <= S_DONE;
          end else begin
            for (int e = 0; e < 3; e++) begin
              w[e]  <= acc[e+1];
              wr[e] <= acc[e+1];
            end
            px    <= minx;
            py    <= miny;
            state <= S_PIX;
          end
        end
        S_PIX: begin
          if (covered) begin
            mstep <= '0;
            state <= S_MUL;
          end else if (last_x && last_y) begin
            state <= S_DONE;
          end else if (last_x) begin
            py <= py + 1'b1;
            px <= minx;
            for (int e = 0; e < 3; e++) begin
              wr[e] <= wr[e] + step_y[e];
              w[e]  <= wr[e] + step_y[e];
            end
          end else begin
            px <= px + 1'b1;
            for (int e = 0; e < 3; e++) w[e] <= w[e] + step_x[e];
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          mstep <= mstep + 1'b1;
          if (mstep == 2'd1)      num <= NUM_W'(prod);
          else if (mstep != 2'd0) num <= num + NUM_W'(prod);
          if (mstep == 2'd3) state <= S_DIVS;
        end
        S_DIVS: state <= S_DIV;
        S_DIV:  if (div_done) state <= S_CMP;
        S_CMP: begin
          if (quot < rd_data) cnt <= cnt + 1'b1;
          if (last_x && last_y) begin
            state <= S_DONE;
          end else if (last_x) begin
            py <= py + 1'b1;
            px <= minx;
            for (int e = 0; e < 3; e++) begin
              wr[e] <= wr[e] + step_y[e];
              w[e]  <= wr[e] + step_y[e];
            end
            state <= S_PIX;
          end else begin
            px <= px + 1'b1;
            for (int e = 0; e < 3; e++) w[e] <= w[e] + step_x[e];
            state <= S_PIX;
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) state <= S_DONE;
        end
        S_RD:  state <= S_RDW;
        S_RDW: begin
          depth_w <= rd_in_store ? rd_data : '0;
          state   <= S_DONE;
        end
        S_DONE: if (!res.valid || res.ready) begin
          res.valid          <= 1'b1;
          res.depth_out      <= depth_w;
          res.pixels_updated <= cnt;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- checks ----
  a_wr_only_clr_cmp: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLR || state == S_CMP))
    else $error("depth store written outside clear or compare");

  a_walk_in_box: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX) |-> (px <= maxx && py <= maxy))
    else $error("pixel walker left the box");

  a_div_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVS) |=> div_busy)
    else $error("divider did not start");

  a_cmp_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> $past(div_done))
    else $error("compare without divider result");

endmodule

`default_nettype wire
